@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers on the block clock and reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FEI_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define FEI_ASSERT_NEVER(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);
`else
`define FEI_ASSERT(lbl, prop, msg)
`define FEI_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

@@ hdl/fei_pkg.sv @@
// ----------------------------------------------------------------------------
// fei_pkg
// Shared constants and fixed-point helpers of the escape-time iterator.
// ----------------------------------------------------------------------------
package fei_pkg;

   // window size, both powers of two
   localparam int WinWidthLog2  = 10;
   localparam int WinHeightLog2 = 10;

   localparam int FracBits = 26;
   localparam int DivNumW  = 52;            // |t| << 24 needs 52 bits
   localparam int DivCntW  = $clog2(DivNumW);

   localparam int CsrAddrW = 3;
   localparam int CsrDataW = 32;

   typedef enum logic [CsrAddrW-1:0] {
      CSR_ZOOM   = 3'd0,
      CSR_PAN_X  = 3'd1,
      CSR_PAN_Y  = 3'd2,
      CSR_C_RE   = 3'd3,
      CSR_C_IM   = 3'd4,
      CSR_LIMIT  = 3'd5,
      CSR_SELECT = 3'd6
   } csr_index_type;

   localparam logic [31:0] ZoomReset  = 32'd16777216;
   localparam logic [15:0] LimitReset = 16'd64;

   localparam logic signed [31:0] SatMax = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] SatMin = 32'sh8000_0000;

   // clamp to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sh0000_0000_7FFF_FFFF) begin
         r = SatMax;
      end else if (v < -64'sh0000_0000_8000_0000) begin
         r = SatMin;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // floor(prod / 2^26), saturated
   function automatic logic signed [31:0] qmul_sat(input logic signed [63:0] prod);
      logic signed [63:0] sh;
      sh = prod >>> FracBits;
      return sat32(sh);
   endfunction

endpackage

@@ hdl/fei_div.sv @@
// ----------------------------------------------------------------------------
// fei_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fei_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [fei_pkg::DivNumW-1:0]     num,
   input  logic [31:0]                     den,
   output logic                            done,
   output logic [fei_pkg::DivNumW-1:0]     quot
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [fei_pkg::DivCntW-1:0]     cnt_ff, cnt_in;
   logic [31:0]                     rem_ff, rem_in;
   logic [31:0]                     den_ff, den_in;
   logic [fei_pkg::DivNumW-1:0]     quo_ff, quo_in;
   logic [32:0]                     trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      trial   = {rem_ff, quo_ff[fei_pkg::DivNumW-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = den;
         quo_in  = num;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = 32'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[fei_pkg::DivNumW-2:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[fei_pkg::DivNumW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == fei_pkg::DivCntW'(fei_pkg::DivNumW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

@@ hdl/fei_mul.sv @@
// ----------------------------------------------------------------------------
// fei_mul
// Shared signed 32x32 multiplier with registered full product.
// ----------------------------------------------------------------------------
module fei_mul (
   input  logic               clock,
   input  logic signed [31:0] op_a,
   input  logic signed [31:0] op_b,
   output logic signed [63:0] prod
);

   logic signed [63:0] prod_ff, prod_in;

   assign prod_in = 64'(op_a) * 64'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

@@ hdl/escape_time_fractal_iterator.sv @@
// ----------------------------------------------------------------------------
// escape_time_fractal_iterator
// Maps a pixel to a start point and iterates a Julia-style formula until
// escape or the iteration limit; returns the iteration count.
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                           | handshake
//  ---------+-----+-----------------------------------+------------------
//  req_     | in  | pixel_x [9:0], pixel_y [19:10]    | tvalid / tready
//  rsp_     | out | escape_count [15:0]               | tvalid / tready
//  csr_     | in  | register index, 32-bit write data | csr_we, no wait
//
//  Flow: the accept, then two divides through the one divider for the
//  start point (52 quotient bits each), then the iteration steps of the
//  abs-weighted mode or the longer step sequence of the cubic mode, all on
//  the single shared multiplier, until the limit check or the escape test
//  ends the loop; then the output register is loaded.
//  Reset is synchronous, active high; it clears the sequencer, the output
//  valid and loads the register reset values.
//  req_tready is high only while the sequencer idles. A finished count waits
//  in the output register; a new item is taken while it waits. The sequencer
//  stalls before loading a new count while the previous one is not taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module escape_time_fractal_iterator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [23:0]                   req_tdata,   // pixel_x [9:0], pixel_y [19:10]
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [15:0]                   rsp_tdata,   // escape_count [15:0]
   input  logic                          csr_we,
   input  logic [fei_pkg::CsrAddrW-1:0]  csr_addr,
   input  logic [fei_pkg::CsrDataW-1:0]  csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_X,
      ST_DIV_Y,
      ST_MUL,
      ST_DONE
   } state_type;

   // configuration registers
   logic [31:0]        zoom_ff;
   logic [9:0]         pan_x_ff;
   logic [9:0]         pan_y_ff;
   logic signed [31:0] c_re_ff;
   logic signed [31:0] c_im_ff;
   logic [15:0]        limit_ff;
   logic               sel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         zoom_ff  <= fei_pkg::ZoomReset;
         pan_x_ff <= '0;
         pan_y_ff <= '0;
         c_re_ff  <= '0;
         c_im_ff  <= '0;
         limit_ff <= fei_pkg::LimitReset;
         sel_ff   <= 1'b0;
      end else if (csr_we) begin
         unique case (fei_pkg::csr_index_type'(csr_addr))
            fei_pkg::CSR_ZOOM:   zoom_ff  <= csr_wdata;
            fei_pkg::CSR_PAN_X:  pan_x_ff <= csr_wdata[9:0];
            fei_pkg::CSR_PAN_Y:  pan_y_ff <= csr_wdata[9:0];
            fei_pkg::CSR_C_RE:   c_re_ff  <= csr_wdata;
            fei_pkg::CSR_C_IM:   c_im_ff  <= csr_wdata;
            fei_pkg::CSR_LIMIT:  limit_ff <= csr_wdata[15:0];
            fei_pkg::CSR_SELECT: sel_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // sequencer state
   state_type          state_ff, state_in;
   logic [2:0]         step_ff, step_in;
   logic [15:0]        iter_ff, iter_in;
   logic [9:0]         py_ff, py_in;
   logic               neg_ff, neg_in;
   logic signed [31:0] re_ff, re_in;
   logic signed [31:0] im_ff, im_in;
   logic signed [63:0] rr_ff, rr_in;
   logic signed [31:0] p_ff, p_in;
   logic signed [31:0] q_ff, q_in;
   logic signed [31:0] t_ff, t_in;
   logic signed [31:0] a_ff, a_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        rsp_data_ff, rsp_data_in;

   // shared units
   logic                            div_start;
   logic [fei_pkg::DivNumW-1:0]     div_num;
   logic [31:0]                     div_den;
   logic                            div_done;
   logic [fei_pkg::DivNumW-1:0]     div_quot;
   logic signed [31:0]              mul_a, mul_b;
   logic signed [63:0]              prod;

   fei_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   fei_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   // start-point terms
   logic [9:0]         req_px, req_py;
   logic signed [29:0] tx, ty;
   logic [28:0]        tx_mag, ty_mag;
   logic signed [63:0] quot_signed;
   logic signed [63:0] pan_term;
   logic signed [31:0] coord;
   logic signed [31:0] prod_q;
   logic signed [31:0] abs_re;
   logic [63:0]        mag;

   assign req_px  = req_tdata[9:0];
   assign req_py  = req_tdata[19:10];
   // 4*p*2^26/W minus two, exact for power-of-two windows
   assign tx      = 30'(req_px) <<< (28 - fei_pkg::WinWidthLog2);
   assign ty      = 30'(py_ff) <<< (28 - fei_pkg::WinHeightLog2);
   assign tx_mag  = (tx >= 30'sd134217728) ? 29'(tx - 30'sd134217728)
                                           : 29'(30'sd134217728 - tx);
   assign ty_mag  = (ty >= 30'sd134217728) ? 29'(ty - 30'sd134217728)
                                           : 29'(30'sd134217728 - ty);
   assign div_den = (zoom_ff == '0) ? 32'd1 : zoom_ff;

   assign quot_signed = neg_ff ? -$signed(64'(div_quot)) : $signed(64'(div_quot));
   assign pan_term    = (state_ff == ST_DIV_X)
                        ? $signed(64'(pan_x_ff) << (fei_pkg::FracBits - fei_pkg::WinWidthLog2))
                        : $signed(64'(pan_y_ff) << (fei_pkg::FracBits - fei_pkg::WinHeightLog2));
   assign coord       = fei_pkg::sat32(quot_signed + pan_term);

   assign prod_q = fei_pkg::qmul_sat(prod);
   assign abs_re = (re_ff == fei_pkg::SatMin) ? fei_pkg::SatMax
                 : (re_ff < 0) ? -re_ff : re_ff;
   assign mag    = 64'(rr_ff) + 64'(prod);

   // operand select for the shared multiplier
   always_comb begin
      mul_a = re_ff;
      mul_b = re_ff;
      case (step_ff)
         3'd1: begin
            mul_a = im_ff;
            mul_b = im_ff;
         end
         3'd2: begin
            mul_a = sel_ff ? prod_q : abs_re;
            mul_b = re_ff;
         end
         3'd3: begin
            mul_a = sel_ff ? p_ff : prod_q;
            mul_b = sel_ff ? re_ff : im_ff;
         end
         3'd4: begin
            mul_a = p_ff;
            mul_b = q_ff;
         end
         default: ;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      iter_in      = iter_ff;
      py_in        = py_ff;
      neg_in       = neg_ff;
      re_in        = re_ff;
      im_in        = im_ff;
      rr_in        = rr_ff;
      p_in         = p_ff;
      q_in         = q_ff;
      t_in         = t_ff;
      a_in         = a_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      div_start    = 1'b0;
      div_num      = {tx_mag, 23'd0} << 1;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               div_start = 1'b1;
               div_num   = fei_pkg::DivNumW'({tx_mag, 24'd0});
               neg_in    = (tx < 30'sd134217728);
               py_in     = req_py;
               state_in  = ST_DIV_X;
            end
         end
         ST_DIV_X: begin
            if (div_done) begin
               re_in     = coord;
               div_start = 1'b1;
               div_num   = fei_pkg::DivNumW'({ty_mag, 24'd0});
               neg_in    = (ty > 30'sd134217728);
               state_in  = ST_DIV_Y;
            end
         end
         ST_DIV_Y: begin
            if (div_done) begin
               im_in    = coord;
               iter_in  = '0;
               step_in  = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            case (step_ff)
               3'd0: begin
                  // stop at the limit before touching z
                  if (iter_ff >= limit_ff) begin
                     state_in = ST_DONE;
                  end else begin
                     step_in = 3'd1;
                  end
               end
               3'd1: begin
                  rr_in   = prod;
                  p_in    = prod_q;
                  step_in = 3'd2;
               end
               3'd2: begin
                  q_in = prod_q;
                  // escape when |z|^2 > 4 in Q.52
                  if (mag > 64'h0040_0000_0000_0000) begin
                     state_in = ST_DONE;
                     step_in  = '0;
                  end else begin
                     step_in = 3'd3;
                  end
               end
               3'd3: begin
                  t_in    = prod_q;
                  step_in = 3'd4;
               end
               3'd4: begin
                  if (!sel_ff) begin
                     re_in   = fei_pkg::sat32(64'(p_ff) - 64'(q_ff) + 64'(c_re_ff));
                     im_in   = fei_pkg::sat32(64'(prod_q) + 64'(c_im_ff));
                     iter_in = iter_ff + 1'b1;
                     step_in = '0;
                  end else begin
                     a_in    = prod_q;
                     step_in = 3'd5;
                  end
               end
               3'd5: begin
                  re_in   = fei_pkg::sat32(64'(a_ff) - (64'(t_ff) <<< 1) - 64'(t_ff)
                                           + 64'(c_re_ff));
                  im_in   = fei_pkg::sat32((64'(prod_q) <<< 1) + 64'(c_im_ff));
                  iter_in = iter_ff + 1'b1;
                  step_in = '0;
               end
               default: step_in = '0;
            endcase
         end
         ST_DONE: begin
            // hold until the output register frees up
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = iter_ff;
               step_in      = '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      iter_ff     <= iter_in;
      py_ff       <= py_in;
      neg_ff      <= neg_in;
      re_ff       <= re_in;
      im_ff       <= im_in;
      rr_ff       <= rr_in;
      p_ff        <= p_in;
      q_ff        <= q_in;
      t_ff        <= t_in;
      a_ff        <= a_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `FEI_ASSERT(a_accept_starts_div, (req_tvalid && req_tready) |=> (state_ff == ST_DIV_X), "accepted item did not start the divide")
   `FEI_ASSERT(a_count_in_limit, $rose(rsp_valid_ff) |-> (rsp_data_ff <= limit_ff), "count exceeds iteration limit")
   `FEI_ASSERT_NEVER(a_step_range, (state_ff == ST_MUL) && (step_ff > 3'd5), "sequencer step out of range")

endmodule
